// ===== hdl/pidaw_pkg.sv =====
// Shared constants, control word and gain types for the PID anti-windup controller.
package pidaw_pkg;

   // Block geometry and fixed-point format
   localparam int NUM_JOINTS = 8;
   localparam int FRAC_BITS  = 16;
   localparam int JOINT_W    = 3;
   localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int DATA_W     = 32;
   localparam int UDATA_W    = 31;
   localparam int INTEG_W    = 48;
   localparam int INTEG_LO_W = INTEG_W / 2;
   localparam int TERM_W     = 64;
   localparam int PD_TERM_W  = 2 * DATA_W - FRAC_BITS;
   localparam int OPND_W     = DATA_W + 1;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int ACC_W      = 96;

   // Sequencer program size
   localparam int NUM_STEPS = 19;
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

   // Register file indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_KP         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_EFFORT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AW_GAIN    = 3'd4;

   // Multiplier A operand
   typedef enum logic [2:0] {
      A_KP,
      A_KI,
      A_KD,
      A_AW,
      A_DT
   } a_sel_type;

   // Multiplier B operand
   typedef enum logic [2:0] {
      B_ERR,
      B_INTEG_LO,
      B_INTEG_HI,
      B_T1_LO,
      B_T1_HI,
      B_NVEL,
      B_DIFF_LO,
      B_DIFF_HI
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_HALF,
      SH_WORD
   } acc_shift_type;

   // Datapath register write targets
   typedef enum logic [3:0] {
      WR_NONE,
      WR_ERR,
      WR_TRAP,
      WR_TKP,
      WR_T1,
      WR_TKD,
      WR_TINT,
      WR_U,
      WR_EFF,
      WR_DIFF,
      WR_CORR,
      WR_INTEG
   } wr_type;

   typedef enum logic {
      JMP_NONE,
      JMP_AW_ZERO
   } jmp_type;

   typedef struct packed {
      a_sel_type          a_sel;
      b_sel_type          b_sel;
      acc_op_type         acc_op;
      acc_shift_type      acc_shift;
      wr_type             wr;
      jmp_type            jmp;
      logic [STEP_W-1:0]  target;
      logic               last;
   } ctrl_word_type;

   typedef struct packed {
      logic aw_zero;
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kp;
      logic signed [DATA_W-1:0] ki;
      logic signed [DATA_W-1:0] kd;
      logic [UDATA_W-1:0]       max_effort;
      logic signed [DATA_W-1:0] aw_gain;
   } gain_set_type;

endpackage

// ===== hdl/pidaw_joint_store.sv =====
// Per-joint integral and previous-error state, cleared at reset.
module pidaw_joint_store (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [pidaw_pkg::JOINT_W-1:0]              rd_joint,
   output logic signed [pidaw_pkg::INTEG_W-1:0]       rd_integ,
   output logic signed [pidaw_pkg::DATA_W-1:0]        rd_prev,
   input  logic                                       wr_en,
   input  logic [pidaw_pkg::JOINT_W-1:0]              wr_joint,
   input  logic signed [pidaw_pkg::INTEG_W-1:0]       wr_integ,
   input  logic signed [pidaw_pkg::DATA_W-1:0]        wr_prev
);

   logic signed [pidaw_pkg::INTEG_W-1:0] integ_ff [pidaw_pkg::NUM_JOINTS];
   logic signed [pidaw_pkg::INTEG_W-1:0] integ_in [pidaw_pkg::NUM_JOINTS];
   logic signed [pidaw_pkg::DATA_W-1:0]  prev_ff  [pidaw_pkg::NUM_JOINTS];
   logic signed [pidaw_pkg::DATA_W-1:0]  prev_in  [pidaw_pkg::NUM_JOINTS];
   logic                                 rd_valid;
   logic                                 wr_valid;
   logic [pidaw_pkg::JIDX_W-1:0]         rd_idx;
   logic [pidaw_pkg::JIDX_W-1:0]         wr_idx;

   assign rd_valid = int'(rd_joint) < pidaw_pkg::NUM_JOINTS;
   assign wr_valid = int'(wr_joint) < pidaw_pkg::NUM_JOINTS;
   assign rd_idx   = pidaw_pkg::JIDX_W'(rd_joint);
   assign wr_idx   = pidaw_pkg::JIDX_W'(wr_joint);

   // Out-of-range joints read as zero state
   assign rd_integ = rd_valid ? integ_ff[rd_idx] : '0;
   assign rd_prev  = rd_valid ? prev_ff[rd_idx]  : '0;

   // Update only the addressed joint; drop writes to joints that do not exist
   always_comb begin
      for (int i = 0; i < pidaw_pkg::NUM_JOINTS; i++) begin
         integ_in[i] = integ_ff[i];
         prev_in[i]  = prev_ff[i];
      end
      if (wr_en && wr_valid) begin
         integ_in[wr_idx] = wr_integ;
         prev_in[wr_idx]  = wr_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pidaw_pkg::NUM_JOINTS; i++) begin
            integ_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else begin
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

// ===== hdl/pidaw_sequencer.sv =====
// Microcode sequencer: step counter, program ROM and conditional jump.
module pidaw_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      stall,
   input  pidaw_pkg::status_type     status,
   output pidaw_pkg::ctrl_word_type  ctrl,
   output logic                      busy,
   output logic                      done
);

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   localparam pidaw_pkg::ctrl_word_type NOP_WORD = '{
      pidaw_pkg::A_KP, pidaw_pkg::B_ERR, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
      pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0};

   // Program: products issue one step ahead of their accumulate, scaled results
   // are committed one step after the accumulate.
   localparam pidaw_pkg::ctrl_word_type ROM [pidaw_pkg::NUM_STEPS] = '{
      // error = sat(goal - position)
      '{pidaw_pkg::A_KP, pidaw_pkg::B_ERR, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_ERR, pidaw_pkg::JMP_NONE, '0, 1'b0},
      // trapezoid into integral, issue kp*error
      '{pidaw_pkg::A_KP, pidaw_pkg::B_ERR, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_TRAP, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_KI, pidaw_pkg::B_INTEG_LO, pidaw_pkg::ACC_LOAD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_KI, pidaw_pkg::B_INTEG_HI, pidaw_pkg::ACC_LOAD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_TKP, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_KD, pidaw_pkg::B_NVEL, pidaw_pkg::ACC_ADD, pidaw_pkg::SH_HALF,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_KD, pidaw_pkg::B_NVEL, pidaw_pkg::ACC_LOAD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_T1, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_DT, pidaw_pkg::B_T1_LO, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_TKD, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_DT, pidaw_pkg::B_T1_HI, pidaw_pkg::ACC_LOAD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_DT, pidaw_pkg::B_T1_HI, pidaw_pkg::ACC_ADD, pidaw_pkg::SH_WORD,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_DT, pidaw_pkg::B_T1_HI, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_TINT, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_LO, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_U, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_LO, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_EFF, pidaw_pkg::JMP_NONE, '0, 1'b0},
      // zero anti-windup gain leaves the integral as is: skip the correction
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_LO, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_DIFF, pidaw_pkg::JMP_AW_ZERO, pidaw_pkg::STEP_LAST, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_LO, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_HI, pidaw_pkg::ACC_LOAD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_HI, pidaw_pkg::ACC_ADD, pidaw_pkg::SH_WORD,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_HI, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_CORR, pidaw_pkg::JMP_NONE, '0, 1'b0},
      '{pidaw_pkg::A_AW, pidaw_pkg::B_DIFF_HI, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_INTEG, pidaw_pkg::JMP_NONE, '0, 1'b0},
      // commit state and hand the result to the output register
      '{pidaw_pkg::A_KP, pidaw_pkg::B_ERR, pidaw_pkg::ACC_HOLD, pidaw_pkg::SH_NONE,
        pidaw_pkg::WR_NONE, pidaw_pkg::JMP_NONE, '0, 1'b1}
   };

   seq_state_type                   state_ff, state_in;
   logic [pidaw_pkg::STEP_W-1:0]    step_ff, step_in;
   pidaw_pkg::ctrl_word_type        word;
   logic                            take_jump;

   assign word      = ROM[step_ff];
   assign take_jump = (word.jmp == pidaw_pkg::JMP_AW_ZERO) && status.aw_zero;
   assign busy      = (state_ff == SEQ_RUN);
   assign done      = busy && word.last && !stall;
   assign ctrl      = busy ? word : NOP_WORD;

   // Advance the step counter; hold on the last step while the output is full
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = '0;
            end
         end
         SEQ_RUN: begin
            if (word.last) begin
               if (!stall) begin
                  state_in = SEQ_IDLE;
               end
            end else if (take_jump) begin
               step_in = word.target;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== hdl/pidaw_datapath.sv =====
// Datapath: operand registers, shared multiplier, accumulator and saturation logic.
module pidaw_datapath (
   input  logic                                  clock,
   input  logic                                  start,
   input  pidaw_pkg::ctrl_word_type              ctrl,
   input  pidaw_pkg::gain_set_type               gains,
   input  logic [pidaw_pkg::JOINT_W-1:0]         req_joint,
   input  logic signed [pidaw_pkg::DATA_W-1:0]   req_goal,
   input  logic signed [pidaw_pkg::DATA_W-1:0]   req_position,
   input  logic signed [pidaw_pkg::DATA_W-1:0]   req_velocity,
   input  logic [pidaw_pkg::UDATA_W-1:0]         req_time_step,
   input  logic signed [pidaw_pkg::INTEG_W-1:0]  rd_integ,
   input  logic signed [pidaw_pkg::DATA_W-1:0]   rd_prev,
   output pidaw_pkg::status_type                 status,
   output logic [pidaw_pkg::JOINT_W-1:0]         joint,
   output logic signed [pidaw_pkg::DATA_W-1:0]   error,
   output logic signed [pidaw_pkg::DATA_W-1:0]   effort,
   output logic signed [pidaw_pkg::INTEG_W-1:0]  integ
);

   localparam int DW  = pidaw_pkg::DATA_W;
   localparam int TW  = pidaw_pkg::TERM_W;
   localparam int IW  = pidaw_pkg::INTEG_W;
   localparam int OW  = pidaw_pkg::OPND_W;
   localparam int AW  = pidaw_pkg::ACC_W;
   localparam int LIM_EXP = TW - 2;

   localparam logic signed [AW-1:0] LIM_POS = AW'(1) << LIM_EXP;
   localparam logic signed [AW-1:0] LIM_NEG = -LIM_POS;
   localparam logic signed [TW:0]   INTEG_MAX = {{(TW + 2 - IW){1'b0}}, {(IW - 1){1'b1}}};
   localparam logic signed [TW:0]   INTEG_MIN = -INTEG_MAX - 1'b1;

   function automatic logic signed [IW-1:0] sat_integ(input logic signed [TW:0] v);
      if (v > INTEG_MAX) begin
         return INTEG_MAX[IW-1:0];
      end else if (v < INTEG_MIN) begin
         return INTEG_MIN[IW-1:0];
      end
      return v[IW-1:0];
   endfunction

   logic [pidaw_pkg::JOINT_W-1:0]          joint_ff, joint_in;
   logic signed [DW-1:0]                   goal_ff, goal_in;
   logic signed [DW-1:0]                   pos_ff, pos_in;
   logic signed [DW-1:0]                   vel_ff, vel_in;
   logic [pidaw_pkg::UDATA_W-1:0]          dt_ff, dt_in;
   logic signed [DW-1:0]                   prev_ff, prev_in;
   logic signed [IW-1:0]                   integ_ff, integ_in;
   logic signed [DW-1:0]                   err_ff, err_in;
   logic signed [pidaw_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic signed [AW-1:0]                   acc_ff, acc_in;
   logic signed [pidaw_pkg::PD_TERM_W-1:0] tkp_ff, tkp_in;
   logic signed [pidaw_pkg::PD_TERM_W-1:0] tkd_ff, tkd_in;
   logic signed [TW-1:0]                   t1_ff, t1_in;
   logic signed [TW-1:0]                   tint_ff, tint_in;
   logic signed [TW-1:0]                   u_ff, u_in;
   logic signed [DW-1:0]                   eff_ff, eff_in;
   logic signed [TW-1:0]                   diff_ff, diff_in;
   logic signed [TW-1:0]                   corr_ff, corr_in;

   logic signed [OW-1:0]                   a_op;
   logic signed [OW-1:0]                   b_op;
   logic signed [OW-1:0]                   nvel;
   logic signed [AW-1:0]                   prod_ext;
   logic signed [AW-1:0]                   prod_sh;
   logic signed [AW-1:0]                   acc_shr;
   logic signed [TW-1:0]                   scaled;
   logic signed [DW:0]                     err_diff;
   logic signed [DW-1:0]                   err_sat;
   logic signed [DW:0]                     trap_sum;
   logic signed [DW-1:0]                   trap_half;
   logic signed [TW:0]                     trap_acc;
   logic signed [TW:0]                     corr_acc;
   logic signed [DW-1:0]                   max_eff;
   logic signed [TW-1:0]                   max_ext;

   assign status.aw_zero = (gains.aw_gain == '0);
   assign joint  = joint_ff;
   assign error  = err_ff;
   assign effort = eff_ff;
   assign integ  = integ_ff;

   // Select multiplier operands
   assign nvel = -(OW'(vel_ff));

   always_comb begin
      unique case (ctrl.a_sel)
         pidaw_pkg::A_KP: a_op = OW'($signed(gains.kp));
         pidaw_pkg::A_KI: a_op = OW'($signed(gains.ki));
         pidaw_pkg::A_KD: a_op = OW'($signed(gains.kd));
         pidaw_pkg::A_AW: a_op = OW'($signed(gains.aw_gain));
         pidaw_pkg::A_DT: a_op = $signed({{(OW - pidaw_pkg::UDATA_W){1'b0}}, dt_ff});
         default:         a_op = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.b_sel)
         pidaw_pkg::B_ERR:      b_op = OW'(err_ff);
         pidaw_pkg::B_INTEG_LO: b_op = $signed({{(OW - pidaw_pkg::INTEG_LO_W){1'b0}},
                                                integ_ff[pidaw_pkg::INTEG_LO_W-1:0]});
         pidaw_pkg::B_INTEG_HI: b_op = OW'($signed(integ_ff[IW-1:pidaw_pkg::INTEG_LO_W]));
         pidaw_pkg::B_T1_LO:    b_op = $signed({1'b0, t1_ff[DW-1:0]});
         pidaw_pkg::B_T1_HI:    b_op = OW'($signed(t1_ff[TW-1:DW]));
         pidaw_pkg::B_NVEL:     b_op = nvel;
         pidaw_pkg::B_DIFF_LO:  b_op = $signed({1'b0, diff_ff[DW-1:0]});
         pidaw_pkg::B_DIFF_HI:  b_op = OW'($signed(diff_ff[TW-1:DW]));
         default:               b_op = '0;
      endcase
   end

   assign prod_in = a_op * b_op;

   // Align the registered product for the accumulator
   assign prod_ext = AW'(prod_ff);

   always_comb begin
      unique case (ctrl.acc_shift)
         pidaw_pkg::SH_NONE: prod_sh = prod_ext;
         pidaw_pkg::SH_HALF: prod_sh = prod_ext <<< pidaw_pkg::INTEG_LO_W;
         pidaw_pkg::SH_WORD: prod_sh = prod_ext <<< DW;
         default:            prod_sh = prod_ext;
      endcase
   end

   always_comb begin
      unique case (ctrl.acc_op)
         pidaw_pkg::ACC_HOLD: acc_in = acc_ff;
         pidaw_pkg::ACC_LOAD: acc_in = prod_sh;
         pidaw_pkg::ACC_ADD:  acc_in = acc_ff + prod_sh;
         default:             acc_in = acc_ff;
      endcase
   end

   // Floor-scale the accumulator and clamp to the product limit
   assign acc_shr = acc_ff >>> pidaw_pkg::FRAC_BITS;

   always_comb begin
      if (acc_shr > LIM_POS) begin
         scaled = LIM_POS[TW-1:0];
      end else if (acc_shr < LIM_NEG) begin
         scaled = LIM_NEG[TW-1:0];
      end else begin
         scaled = acc_shr[TW-1:0];
      end
   end

   // Saturating position error
   assign err_diff = (DW + 1)'(goal_ff) - (DW + 1)'(pos_ff);

   always_comb begin
      if (err_diff[DW] != err_diff[DW-1]) begin
         err_sat = err_diff[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
      end else begin
         err_sat = err_diff[DW-1:0];
      end
   end

   // Trapezoid step and anti-windup correction
   assign trap_sum  = (DW + 1)'(err_ff) + (DW + 1)'(prev_ff);
   assign trap_half = trap_sum[DW:1];
   assign trap_acc  = (TW + 1)'(integ_ff) + (TW + 1)'(trap_half);
   assign corr_acc  = (TW + 1)'(integ_ff) + (TW + 1)'(corr_ff);

   // Effort clamp limit
   assign max_eff = $signed({1'b0, gains.max_effort});
   assign max_ext = TW'(max_eff);

   // Load the transaction on start, then write the target the step selects
   always_comb begin
      joint_in = joint_ff;
      goal_in  = goal_ff;
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      dt_in    = dt_ff;
      prev_in  = prev_ff;
      integ_in = integ_ff;
      err_in   = err_ff;
      tkp_in   = tkp_ff;
      tkd_in   = tkd_ff;
      t1_in    = t1_ff;
      tint_in  = tint_ff;
      u_in     = u_ff;
      eff_in   = eff_ff;
      diff_in  = diff_ff;
      corr_in  = corr_ff;
      if (start) begin
         joint_in = req_joint;
         goal_in  = req_goal;
         pos_in   = req_position;
         vel_in   = req_velocity;
         dt_in    = req_time_step;
         prev_in  = rd_prev;
         integ_in = rd_integ;
      end else begin
         unique case (ctrl.wr)
            pidaw_pkg::WR_NONE:  ;
            pidaw_pkg::WR_ERR:   err_in   = err_sat;
            pidaw_pkg::WR_TRAP:  integ_in = sat_integ(trap_acc);
            pidaw_pkg::WR_TKP:   tkp_in   = scaled[pidaw_pkg::PD_TERM_W-1:0];
            pidaw_pkg::WR_T1:    t1_in    = scaled;
            pidaw_pkg::WR_TKD:   tkd_in   = scaled[pidaw_pkg::PD_TERM_W-1:0];
            pidaw_pkg::WR_TINT:  tint_in  = scaled;
            pidaw_pkg::WR_U:     u_in     = TW'(tkp_ff) + tint_ff + TW'(tkd_ff);
            pidaw_pkg::WR_EFF: begin
               if (u_ff > max_ext) begin
                  eff_in = max_eff;
               end else if (u_ff < -max_ext) begin
                  eff_in = -max_eff;
               end else begin
                  eff_in = u_ff[DW-1:0];
               end
            end
            pidaw_pkg::WR_DIFF:  diff_in  = TW'(eff_ff) - u_ff;
            pidaw_pkg::WR_CORR:  corr_in  = scaled;
            pidaw_pkg::WR_INTEG: integ_in = sat_integ(corr_acc);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      joint_ff <= joint_in;
      goal_ff  <= goal_in;
      pos_ff   <= pos_in;
      vel_ff   <= vel_in;
      dt_ff    <= dt_in;
      prev_ff  <= prev_in;
      integ_ff <= integ_in;
      err_ff   <= err_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      tkp_ff   <= tkp_in;
      tkd_ff   <= tkd_in;
      t1_ff    <= t1_in;
      tint_ff  <= tint_in;
      u_ff     <= u_in;
      eff_ff   <= eff_in;
      diff_ff  <= diff_in;
      corr_ff  <= corr_in;
   end

endmodule

// ===== hdl/pid_antiwindup_controller.sv =====
// Top level of the PID controller with back-calculation anti-windup.
//
// Each req_ transaction is one control tick for one joint. The block forms the
// saturated position error, adds the trapezoid of this and the joint's previous
// error to the joint's integral, and returns the effort clamped to +/- max_effort
// together with the error on the rsp_ channel. The integral is then corrected by
// aw_gain times the clamping loss and stored with the new error.
// Gains are written through the csr_ port (index 0 kp, 1 ki, 2 kd, 3 max_effort,
// 4 aw_gain); the user must do so only while no tick is in flight, as the block
// does not check it. csr_ready is always high. A tick is a 19-step microprogram
// on one shared 33x33 multiplier and a 96-bit accumulator; the multiply chain of
// the integral term sets the length, and a zero aw_gain skips the correction
// steps. Ticks do not overlap. The result sits in an output register, so the
// next tick is accepted while it waits; if rsp_ready is still low when that
// next tick finishes, the sequencer holds on its last step until it drains.
// Reset clears the gains and every joint's integral and previous error.
module pid_antiwindup_controller (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [pidaw_pkg::JOINT_W-1:0]             req_joint,
   input  logic signed [pidaw_pkg::DATA_W-1:0]       req_goal,
   input  logic signed [pidaw_pkg::DATA_W-1:0]       req_position,
   input  logic signed [pidaw_pkg::DATA_W-1:0]       req_velocity,
   input  logic [pidaw_pkg::UDATA_W-1:0]             req_time_step,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [pidaw_pkg::JOINT_W-1:0]             rsp_joint_out,
   output logic signed [pidaw_pkg::DATA_W-1:0]       rsp_effort,
   output logic signed [pidaw_pkg::DATA_W-1:0]       rsp_error_out,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [pidaw_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]              csr_data
);

   pidaw_pkg::gain_set_type                  gains_ff, gains_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [pidaw_pkg::JOINT_W-1:0]            rsp_joint_ff, rsp_joint_in;
   logic signed [pidaw_pkg::DATA_W-1:0]      rsp_effort_ff, rsp_effort_in;
   logic signed [pidaw_pkg::DATA_W-1:0]      rsp_error_ff, rsp_error_in;

   pidaw_pkg::ctrl_word_type                 ctrl;
   pidaw_pkg::status_type                    status;
   logic                                     seq_busy;
   logic                                     seq_done;
   logic                                     start;
   logic                                     stall;
   logic signed [pidaw_pkg::INTEG_W-1:0]     rd_integ;
   logic signed [pidaw_pkg::DATA_W-1:0]      rd_prev;
   logic [pidaw_pkg::JOINT_W-1:0]            dp_joint;
   logic signed [pidaw_pkg::DATA_W-1:0]      dp_error;
   logic signed [pidaw_pkg::DATA_W-1:0]      dp_effort;
   logic signed [pidaw_pkg::INTEG_W-1:0]     dp_integ;

   assign req_ready     = !seq_busy;
   assign start         = req_valid && req_ready;
   assign stall         = rsp_valid_ff && !rsp_ready;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_joint_out = rsp_joint_ff;
   assign rsp_effort    = rsp_effort_ff;
   assign rsp_error_out = rsp_error_ff;

   pidaw_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .stall  (stall),
      .status (status),
      .ctrl   (ctrl),
      .busy   (seq_busy),
      .done   (seq_done)
   );

   pidaw_joint_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_joint (req_joint),
      .rd_integ (rd_integ),
      .rd_prev  (rd_prev),
      .wr_en    (seq_done),
      .wr_joint (dp_joint),
      .wr_integ (dp_integ),
      .wr_prev  (dp_error)
   );

   pidaw_datapath u_dp (
      .clock         (clock),
      .start         (start),
      .ctrl          (ctrl),
      .gains         (gains_ff),
      .req_joint     (req_joint),
      .req_goal      (req_goal),
      .req_position  (req_position),
      .req_velocity  (req_velocity),
      .req_time_step (req_time_step),
      .rd_integ      (rd_integ),
      .rd_prev       (rd_prev),
      .status        (status),
      .joint         (dp_joint),
      .error         (dp_error),
      .effort        (dp_effort),
      .integ         (dp_integ)
   );

   // Write the addressed gain register; drop writes beyond the register list
   always_comb begin
      gains_in = gains_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pidaw_pkg::REG_KP:         gains_in.kp         = $signed(csr_data);
            pidaw_pkg::REG_KI:         gains_in.ki         = $signed(csr_data);
            pidaw_pkg::REG_KD:         gains_in.kd         = $signed(csr_data);
            pidaw_pkg::REG_MAX_EFFORT: gains_in.max_effort =
                                          csr_data[pidaw_pkg::UDATA_W-1:0];
            pidaw_pkg::REG_AW_GAIN:    gains_in.aw_gain    = $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Load the output register on completion, clear it when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_joint_in  = rsp_joint_ff;
      rsp_effort_in = rsp_effort_ff;
      rsp_error_in  = rsp_error_ff;
      if (seq_done) begin
         rsp_valid_in  = 1'b1;
         rsp_joint_in  = dp_joint;
         rsp_effort_in = dp_effort;
         rsp_error_in  = dp_error;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gains_ff     <= gains_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_joint_ff  <= rsp_joint_in;
      rsp_effort_ff <= rsp_effort_in;
      rsp_error_ff  <= rsp_error_in;
   end

   // A finished tick never overwrites a result that is still waiting
   a_done_slot: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result completed while output register full");

   // An accepted tick starts the microprogram on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> seq_busy)
      else $error("sequencer not running after accepted transaction");

   // A result appears only from a completed microprogram
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_done))
      else $error("result valid without a completed tick");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the PID anti-windup controller against a bit-true tick predictor.
module tb_top;
   import pidaw_pkg::*;

   localparam int WIDE_W     = 128;
   localparam int IDLE_LIMIT = 2000;
   localparam int END_CYCLES = 60;
   // Indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] REG_HOLE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOLE_HI = 3'd7;

   typedef logic signed [WIDE_W-1:0] wide_t;

   typedef enum logic [1:0] {
      PLAN_TICK,
      PLAN_CSR,
      PLAN_DRAIN
   } plan_kind_t;

   typedef struct packed {
      plan_kind_t                kind;
      logic [JOINT_W-1:0]        joint;
      logic signed [DATA_W-1:0]  goal;
      logic signed [DATA_W-1:0]  position;
      logic signed [DATA_W-1:0]  velocity;
      logic [UDATA_W-1:0]        time_step;
      logic [CSR_IDX_W-1:0]      index;
      logic [DATA_W-1:0]         data;
   } plan_t;

   typedef struct packed {
      logic [JOINT_W-1:0]        joint;
      logic signed [DATA_W-1:0]  effort;
      logic signed [DATA_W-1:0]  error;
   } effort_rec_t;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [JOINT_W-1:0]         req_joint = '0;
   logic signed [DATA_W-1:0]   req_goal = '0;
   logic signed [DATA_W-1:0]   req_position = '0;
   logic signed [DATA_W-1:0]   req_velocity = '0;
   logic [UDATA_W-1:0]         req_time_step = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [JOINT_W-1:0]         rsp_joint_out;
   logic signed [DATA_W-1:0]   rsp_effort;
   logic signed [DATA_W-1:0]   rsp_error_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [DATA_W-1:0]          csr_data = '0;

   plan_t       tick_plan_q[$];
   effort_rec_t effort_due_q[$];

   // Predictor copy of the gains and per-joint state
   gain_set_type              gains;
   logic signed [INTEG_W-1:0] integ_mem [NUM_JOINTS];
   logic signed [DATA_W-1:0]  prev_err_mem [NUM_JOINTS];

   int  ticks_sent = 0;
   int  ticks_done = 0;
   int  errors = 0;
   int  drv_gap = 0;
   int  rsp_gap = 0;
   int  stall_cycles = 0;
   int  calm_left = 0;
   logic calm = 1'b0;

   pid_antiwindup_controller u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_joint     (req_joint),
      .req_goal      (req_goal),
      .req_position  (req_position),
      .req_velocity  (req_velocity),
      .req_time_step (req_time_step),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_joint_out (rsp_joint_out),
      .rsp_effort    (rsp_effort),
      .rsp_error_out (rsp_error_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic wide_t clip(input wide_t v, input wide_t lo, input wide_t hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Exact product, floored by the fraction width, clipped to +/- 2^62
   function automatic wide_t mul_floor(input wide_t a, input wide_t b);
      wide_t prod;
      wide_t lim;
      lim  = wide_t'(1) <<< 62;
      prod = a * b;
      return clip(prod >>> FRAC_BITS, -lim, lim);
   endfunction

   task automatic pid_predict(input plan_t t, output effort_rec_t r);
      wide_t integ, prev, err, u, eff, corr, m;
      wide_t g, p, v, dt, kp, ki, kd, aw;
      wide_t i48_hi, i48_lo, e32_hi, e32_lo;
      logic  in_range;
      i48_hi   = (wide_t'(1) <<< (INTEG_W - 1)) - 1;
      i48_lo   = -(wide_t'(1) <<< (INTEG_W - 1));
      e32_hi   = (wide_t'(1) <<< (DATA_W - 1)) - 1;
      e32_lo   = -(wide_t'(1) <<< (DATA_W - 1));
      in_range = int'(t.joint) < NUM_JOINTS;
      integ    = 0;
      prev     = 0;
      if (in_range) begin
         integ = integ_mem[t.joint];
         prev  = prev_err_mem[t.joint];
      end
      g  = t.goal;
      p  = t.position;
      v  = t.velocity;
      dt = t.time_step;
      kp = gains.kp;
      ki = gains.ki;
      kd = gains.kd;
      aw = gains.aw_gain;
      m  = gains.max_effort;
      // Saturated error, then trapezoid into the integral
      err   = clip(g - p, e32_lo, e32_hi);
      integ = clip(integ + ((err + prev) >>> 1), i48_lo, i48_hi);
      u = mul_floor(kp, err) + mul_floor(mul_floor(ki, integ), dt) + mul_floor(kd, -v);
      if (u > m) eff = m;
      else if (u < -m) eff = -m;
      else eff = u;
      // Back-calculation correction of the integral
      corr  = mul_floor(aw, eff - u);
      integ = clip(integ + corr, i48_lo, i48_hi);
      if (in_range) begin
         integ_mem[t.joint]    = integ[INTEG_W-1:0];
         prev_err_mem[t.joint] = err[DATA_W-1:0];
      end
      r.joint  = t.joint;
      r.effort = eff[DATA_W-1:0];
      r.error  = err[DATA_W-1:0];
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
      case (idx)
         REG_KP:         gains.kp = d;
         REG_KI:         gains.ki = d;
         REG_KD:         gains.kd = d;
         REG_MAX_EFFORT: gains.max_effort = d[UDATA_W-1:0];
         REG_AW_GAIN:    gains.aw_gain = d;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- pacing

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Alternate stretches of random idling with stretches of none
   always @(posedge clock) begin
      if (calm_left != 0) begin
         calm_left <= calm_left - 1;
      end else begin
         calm      <= ~calm;
         calm_left <= $urandom_range(50, 300);
      end
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      plan_t       nxt;
      plan_t       cur;
      effort_rec_t pred;
      logic        req_fire;
      logic        csr_fire;
      logic        quiet;
      if (reset) begin
         req_valid  <= 1'b0;
         csr_valid  <= 1'b0;
         drv_gap    <= 0;
         ticks_sent <= 0;
         gains = '0;
         for (int i = 0; i < NUM_JOINTS; i++) begin
            integ_mem[i]    = '0;
            prev_err_mem[i] = '0;
         end
      end else begin
         req_fire = req_valid && req_ready;
         csr_fire = csr_valid && csr_ready;
         // Predict each accepted tick with the gains in force
         if (req_fire) begin
            cur           = '0;
            cur.kind      = PLAN_TICK;
            cur.joint     = req_joint;
            cur.goal      = req_goal;
            cur.position  = req_position;
            cur.velocity  = req_velocity;
            cur.time_step = req_time_step;
            pid_predict(cur, pred);
            effort_due_q.push_back(pred);
            ticks_sent <= ticks_sent + 1;
         end
         if (csr_fire) apply_csr(csr_index, csr_data);
         quiet = !req_fire && (ticks_sent == ticks_done) && req_ready;
         // Hold a pending transaction, idle out a gap, or start the next plan entry
         if ((req_valid && !req_fire) || (csr_valid && !csr_fire)) begin
         end else if (drv_gap != 0) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
            drv_gap   <= drv_gap - 1;
         end else if (tick_plan_q.size() == 0) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else begin
            nxt = tick_plan_q[0];
            case (nxt.kind)
               PLAN_TICK: begin
                  req_valid     <= 1'b1;
                  csr_valid     <= 1'b0;
                  req_joint     <= nxt.joint;
                  req_goal      <= nxt.goal;
                  req_position  <= nxt.position;
                  req_velocity  <= nxt.velocity;
                  req_time_step <= nxt.time_step;
                  drv_gap       <= pick_gap();
                  void'(tick_plan_q.pop_front());
               end
               PLAN_CSR: begin
                  req_valid <= 1'b0;
                  if (quiet) begin
                     csr_valid <= 1'b1;
                     csr_index <= nxt.index;
                     csr_data  <= nxt.data;
                     void'(tick_plan_q.pop_front());
                  end else begin
                     csr_valid <= 1'b0;
                  end
               end
               default: begin
                  req_valid <= 1'b0;
                  csr_valid <= 1'b0;
                  if (quiet) void'(tick_plan_q.pop_front());
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      effort_rec_t want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         rsp_gap    <= 0;
         ticks_done <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            ticks_done <= ticks_done + 1;
            if (effort_due_q.size() == 0) begin
               $display("%0t: unexpected result joint %0d effort %0d error %0d",
                        $time, rsp_joint_out, rsp_effort, rsp_error_out);
               errors++;
            end else begin
               want = effort_due_q.pop_front();
               if (rsp_joint_out !== want.joint) begin
                  $display("%0t: joint_out expected %0d actual %0d",
                           $time, want.joint, rsp_joint_out);
                  errors++;
               end
               if (rsp_effort !== want.effort) begin
                  $display("%0t: effort expected %0d actual %0d",
                           $time, want.effort, rsp_effort);
                  errors++;
               end
               if (rsp_error_out !== want.error) begin
                  $display("%0t: error_out expected %0d actual %0d",
                           $time, want.error, rsp_error_out);
                  errors++;
               end
            end
         end
         // Stall the result channel at random
         if (rsp_gap != 0) begin
            rsp_ready <= 1'b0;
            rsp_gap   <= rsp_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap   <= pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_tick(input logic [JOINT_W-1:0] j, input logic [DATA_W-1:0] g,
                           input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] v,
                           input logic [UDATA_W-1:0] dt);
      plan_t e;
      e           = '0;
      e.kind      = PLAN_TICK;
      e.joint     = j;
      e.goal      = g;
      e.position  = p;
      e.velocity  = v;
      e.time_step = dt;
      tick_plan_q.push_back(e);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
      plan_t e;
      e       = '0;
      e.kind  = PLAN_CSR;
      e.index = idx;
      e.data  = d;
      tick_plan_q.push_back(e);
   endtask

   task automatic add_gains(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                            input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] m,
                            input logic [DATA_W-1:0] aw);
      add_csr(REG_KP, kp);
      add_csr(REG_KI, ki);
      add_csr(REG_KD, kd);
      add_csr(REG_MAX_EFFORT, m);
      add_csr(REG_AW_GAIN, aw);
   endtask

   task automatic add_drain();
      plan_t e;
      e      = '0;
      e.kind = PLAN_DRAIN;
      tick_plan_q.push_back(e);
   endtask

   function automatic logic [DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_gain();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return pick_extreme();
      if (roll == 1) return $urandom;
      // Mostly moderate gains within +/- 8.0
      return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
   endfunction

   function automatic logic [DATA_W-1:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 3) return $urandom;
      if (roll == 3) return pick_extreme();
      return $urandom_range(0, 32'h0100_0000);
   endfunction

   function automatic logic [DATA_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 5) return $urandom;
      if (roll < 8) return pick_extreme();
      // Mostly positions near the origin, within +/- 256.0
      return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
   endfunction

   function automatic logic [UDATA_W-1:0] pick_step();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return UDATA_W'($urandom);
      if (roll == 2) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return $urandom_range(0, 32'h0002_0000);
   endfunction

   initial begin
      // Zero gains after reset, error saturating both ways, spare indexes
      add_tick(3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_0000);
      add_tick(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      add_tick(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_0000);
      add_csr(REG_HOLE_LO, 32'hFFFF_FFFF);
      add_csr(REG_HOLE_HI, 32'hFFFF_FFFF);
      add_tick(3'd1, 32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 31'h0000_028F);

      // Ordinary gains: tracking, effort clamp with correction, dt at both ends
      add_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000, 32'h0002_0000);
      add_tick(3'd1, 32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 31'h0000_028F);
      add_tick(3'd1, 32'h0005_0000, 32'h0004_0000, 32'hFFFF_0000, 31'h0000_028F);
      add_tick(3'd2, 32'hFFF0_0000, 32'h0003_0000, 32'h0000_0000, 31'h0000_1000);
      add_tick(3'd3, 32'h7530_0000, 32'h8AD0_0000, 32'h0000_0000, 31'h0001_0000);
      add_tick(3'd3, 32'h7530_0000, 32'h8AD0_0000, 32'h0000_0000, 31'h0001_0000);
      add_tick(3'd3, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 31'h0000_0000);
      add_tick(3'd2, 32'h0001_0001, 32'h0000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);

      // Extreme gains, zero clamp: the correction drives the integral to its rails
      add_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      add_tick(3'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      add_tick(3'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      add_tick(3'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF);
      add_tick(3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);

      // Opposite extremes, widest clamp
      add_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      add_tick(3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      add_tick(3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0000_FFFF);
      add_tick(3'd6, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 31'h0000_0001);

      // Integral gain and anti-windup gain both zero
      add_gains(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 32'h0032_0000, 32'h0000_0000);
      add_tick(3'd6, 32'h0100_0000, 32'hFF00_0000, 32'h0001_0000, 31'h0000_8000);
      add_tick(3'd6, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_8000);
      add_tick(3'd7, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_8000);

      // Random phases, each under fresh gains; pause once for a full drain
      for (int ph = 0; ph < 6; ph++) begin
         add_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                   ($urandom_range(0, 3) == 0) ? 32'h0 : pick_gain());
         for (int n = 0; n < 80; n++) begin
            if (ph == 2 && n == 40) add_drain();
            add_tick(JOINT_W'($urandom_range(0, NUM_JOINTS - 1)), pick_word(), pick_word(),
                     pick_word(), pick_step());
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for the plan to run out and every result to come back
      @(negedge clock);
      while (tick_plan_q.size() != 0 || req_valid || csr_valid || ticks_sent != ticks_done)
         @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (effort_due_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, effort_due_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
